FILE: src/rgb_status_led_fader_top_macros.svh
// ----------------------------------------------------------------------------
// rgb_status_led_fader_top_macros
// Assertion macros used by the status LED fader top module.
// ----------------------------------------------------------------------------
`ifndef RGB_STATUS_LED_FADER_TOP_MACROS_SVH
`define RGB_STATUS_LED_FADER_TOP_MACROS_SVH

// check that cons holds in the same cycle as ante
`define RSF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsf same-cycle check failed");

// check that cons holds in the cycle after ante
`define RSF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsf next-cycle check failed");

`endif

FILE: src/rsf_pkg.sv
// ----------------------------------------------------------------------------
// rsf_pkg
// Types, register codes and helpers for the status LED fader.
// ----------------------------------------------------------------------------
package rsf_pkg;

    localparam int CHANNELS_DEF = 3;
    localparam int PINS         = 3;
    localparam int LEVEL_W      = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 32;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

    localparam logic [7:0] TPS_RST           = 8'd250;
    localparam logic [7:0] RUN_TIMEOUT_RST   = 8'd30;
    localparam logic [7:0] START_TIMEOUT_RST = 8'd60;
    localparam logic [3:0] START_EDGES_RST   = 4'd4;
    localparam logic [3:0] INPUT_DELAY_RST   = 4'd5;
    localparam logic [3:0] FRAME_TICKS_RST   = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKS_PER_SECOND  = 3'd0,
        REG_RUN_TIMEOUT_S     = 3'd1,
        REG_STARTUP_TIMEOUT_S = 3'd2,
        REG_STARTUP_EDGES     = 3'd3,
        REG_INPUT_DELAY_TICKS = 3'd4,
        REG_FRAME_TICKS       = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_EVENT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_CHANGE = 2'd1,
        MODE_BLINK  = 2'd2
    } mode_t;

    typedef struct packed {
        logic frame;
        logic apply_err;
        logic sample;
    } frame_ctl_t;

    // floor(v / 20) for 8-bit v by reciprocal multiply
    function automatic logic [LEVEL_W-1:0] div20(input logic [LEVEL_W-1:0] v);
        logic [15:0] p;
        p = {8'd0, v} * 16'd205;
        return {4'd0, p[15:12]};
    endfunction

endpackage

FILE: src/rgb_status_led_fader_top.sv
// Flow: an accepted transfer waits in the input holding register and is processed
//   once the output slot is free; its result is presented from then on.
// Throughput: one item per cycle unless m_tready stalls; the input holding
//   register and the result-forming state registers update in the same cycle.
// Reset: rst_n asynchronous, active low; registers return to their defaults,
//   duties and goals clear, blue channel starts blinking.
// ----------------------------------------------------------------------------
// rgb_status_led_fader_top
// Three-channel status LED fader with tick/pin-event stream input.
// ----------------------------------------------------------------------------
`include "rgb_status_led_fader_top_macros.svh"

module rgb_status_led_fader_top
    import rsf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [2:0] pin_levels
    input  logic                  s_tuser,   // [0] op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] red_level, [15:8] green_level, [23:16] blue_level, [24] red_enable,
    // [25] green_enable, [26] blue_enable, [27] watchdog_error, [28] locked
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic            in_valid_reg, in_valid_next;
    logic            in_op_reg;
    logic [PINS-1:0] in_pins_reg;
    logic            out_valid_reg, out_valid_next;
    logic            adv;

    frame_ctl_t          ctl;
    logic                wdt_error, locked;
    logic [CHANNELS-1:0] pin_bit;
    logic [CHANNELS-1:0] ch_en;
    logic [LEVEL_W-1:0]  ch_level [CHANNELS];
    logic [LEVEL_W-1:0]  out_level [3];
    logic [2:0]          out_en;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_pins_reg <= s_tdata[PINS-1:0];
        end
    end

    rsf_timebase u_timebase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .adv       (adv),
        .op        (in_op_reg),
        .ctl       (ctl),
        .wdt_error (wdt_error),
        .locked    (locked)
    );

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_ch
        if (c < PINS)
        begin : g_pin
            assign pin_bit[c] = in_pins_reg[PINS-1-c];
        end
        else
        begin : g_nopin
            assign pin_bit[c] = 1'b0;
        end

        rsf_channel #(
            .IDX (c)
        ) u_channel (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .pin    (pin_bit[c]),
            .level  (ch_level[c]),
            .enable (ch_en[c])
        );
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_out
        if (k < CHANNELS)
        begin : g_used
            assign out_level[k] = ch_level[k];
            assign out_en[k]    = ch_en[k];
        end
        else
        begin : g_unused
            assign out_level[k] = '0;
            assign out_en[k]    = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, locked, wdt_error, out_en,
                       out_level[2], out_level[1], out_level[0]};

    `RSF_ASSERT_IMP(a_lock_needs_error, locked, wdt_error)
    `RSF_ASSERT_NXT(a_adv_gives_result, adv, m_tvalid)
    `RSF_ASSERT_IMP(a_no_adv_on_stall, m_tvalid && !m_tready, !adv)
    `RSF_ASSERT_NXT(a_lock_sticky, locked, locked)

endmodule

FILE: src/rsf_timebase.sv
// ----------------------------------------------------------------------------
// rsf_timebase
// Configuration registers, tick/second/frame counters, debounce and watchdog.
// ----------------------------------------------------------------------------
module rsf_timebase
    import rsf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  adv,
    input  logic                  op,
    output frame_ctl_t            ctl,
    output logic                  wdt_error,
    output logic                  locked
);

    logic [7:0] tps_reg, run_to_reg, start_to_reg;
    logic [3:0] delay_reg, frame_ticks_reg;

    logic [3:0] dcnt_reg, dcnt_next;
    logic       idle_reg, idle_next;
    logic [3:0] start_left_reg, start_left_next;
    logic [7:0] tick_reg, tick_next;
    logic [7:0] sec_reg, sec_next;
    logic [3:0] frame_reg, frame_next;
    logic       wdt_reg, wdt_next;
    logic       lock_reg, lock_next;

    logic [3:0] dcnt_dec;
    logic [7:0] tick_inc, sec_inc, timeout;
    logic [3:0] frame_inc;
    logic       sec_roll, frame_go, wdt_new, is_tick, is_event;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg         <= TPS_RST;
            run_to_reg      <= RUN_TIMEOUT_RST;
            start_to_reg    <= START_TIMEOUT_RST;
            delay_reg       <= INPUT_DELAY_RST;
            frame_ticks_reg <= FRAME_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TICKS_PER_SECOND:  tps_reg         <= cfg_wdata;
                REG_RUN_TIMEOUT_S:     run_to_reg      <= cfg_wdata;
                REG_STARTUP_TIMEOUT_S: start_to_reg    <= cfg_wdata;
                REG_INPUT_DELAY_TICKS: delay_reg       <= cfg_wdata[3:0];
                REG_FRAME_TICKS:       frame_ticks_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign is_tick  = adv && (op == OP_TICK);
    assign is_event = adv && (op == OP_EVENT);

    assign dcnt_dec  = (!idle_reg && dcnt_reg != 4'd0) ? dcnt_reg - 4'd1 : dcnt_reg;
    assign tick_inc  = tick_reg + 8'd1;
    assign sec_roll  = tick_inc >= tps_reg;
    assign sec_inc   = (sec_reg == 8'd255) ? sec_reg : sec_reg + 8'd1;
    assign timeout   = (start_left_reg == 4'd0) ? run_to_reg : start_to_reg;
    assign wdt_new   = wdt_reg || (sec_roll && sec_inc == timeout);
    assign frame_inc = frame_reg + 4'd1;
    assign frame_go  = frame_inc >= frame_ticks_reg;

    always_comb
    begin
        ctl.frame     = is_tick && frame_go;
        ctl.apply_err = ctl.frame && !lock_reg && wdt_new;
        ctl.sample    = ctl.frame && !lock_reg && !wdt_new && !idle_reg &&
                        dcnt_dec == 4'd0;
    end

    always_comb
    begin
        dcnt_next       = dcnt_reg;
        idle_next       = idle_reg;
        start_left_next = start_left_reg;
        tick_next       = tick_reg;
        sec_next        = sec_reg;
        frame_next      = frame_reg;
        wdt_next        = wdt_reg;
        lock_next       = lock_reg;
        if (is_tick)
        begin
            dcnt_next  = dcnt_dec;
            tick_next  = sec_roll ? 8'd0 : tick_inc;
            sec_next   = sec_roll ? sec_inc : sec_reg;
            wdt_next   = wdt_new;
            frame_next = frame_go ? 4'd0 : frame_inc;
            if (ctl.apply_err)
                lock_next = 1'b1;
            if (ctl.sample)
                idle_next = 1'b1;
        end
        else if (is_event)
        begin
            if (start_left_reg != 4'd0)
                start_left_next = start_left_reg - 4'd1;
            else
            begin
                if (idle_reg)
                begin
                    dcnt_next = delay_reg;
                    idle_next = 1'b0;
                end
                sec_next = 8'd0;
            end
        end
        if (cfg_we && cfg_index == REG_STARTUP_EDGES)
            start_left_next = cfg_wdata[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg       <= 4'd0;
            idle_reg       <= 1'b1;
            start_left_reg <= START_EDGES_RST;
            tick_reg       <= 8'd0;
            sec_reg        <= 8'd0;
            frame_reg      <= 4'd0;
            wdt_reg        <= 1'b0;
            lock_reg       <= 1'b0;
        end
        else
        begin
            dcnt_reg       <= dcnt_next;
            idle_reg       <= idle_next;
            start_left_reg <= start_left_next;
            tick_reg       <= tick_next;
            sec_reg        <= sec_next;
            frame_reg      <= frame_next;
            wdt_reg        <= wdt_next;
            lock_reg       <= lock_next;
        end
    end

    assign wdt_error = wdt_reg;
    assign locked    = lock_reg;

endmodule

FILE: src/rsf_channel.sv
// ----------------------------------------------------------------------------
// rsf_channel
// One LED channel: goal update, then ramp, blink or finish a change per frame.
// ----------------------------------------------------------------------------
module rsf_channel
    import rsf_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  frame_ctl_t         ctl,
    input  logic               pin,
    output logic [LEVEL_W-1:0] level,
    output logic               enable
);

    localparam logic IS_FIRST  = (IDX == 0);
    localparam logic BLINK_RST = (IDX == 2);

    logic [LEVEL_W-1:0] duty_reg, duty_next;
    logic [LEVEL_W-1:0] goal_reg, goal_next;
    mode_t              mode_reg, mode_next;
    logic               en_reg, en_next;

    logic [LEVEL_W-1:0] g1;
    mode_t              m1;
    logic               e1;
    logic [LEVEL_W-1:0] diff;
    logic [LEVEL_W:0]   up;

    always_comb
    begin
        g1 = goal_reg;
        m1 = mode_reg;
        e1 = en_reg;
        priority if (ctl.apply_err)
        begin
            if (IS_FIRST)
            begin
                m1 = MODE_BLINK;
                e1 = 1'b1;
            end
            else
            begin
                g1 = '0;
                m1 = MODE_CHANGE;
            end
        end
        else if (ctl.sample)
        begin
            if (pin)
            begin
                g1 = FULL_LEVEL;
                e1 = 1'b1;
                m1 = MODE_CHANGE;
            end
            else if (goal_reg != '0)
            begin
                g1 = '0;
                e1 = 1'b1;
                m1 = MODE_CHANGE;
            end
        end
        else
        begin
        end
    end

    assign diff = duty_reg - g1;
    assign up   = {1'b0, duty_reg} + {1'b0, div20(duty_reg)} + 9'd1;

    always_comb
    begin
        duty_next = duty_reg;
        goal_next = g1;
        mode_next = m1;
        en_next   = e1;
        priority if (duty_reg == g1 && m1 != MODE_WAIT)
        begin
            unique case (m1)
                MODE_BLINK:
                    goal_next = (g1 == '0) ? FULL_LEVEL : '0;
                MODE_CHANGE:
                begin
                    if (g1 == '0)
                        en_next = 1'b0;
                    mode_next = MODE_WAIT;
                end
                default: ;
            endcase
        end
        else if (duty_reg > g1)
            duty_next = duty_reg - (div20(diff) + 8'd1);
        else
            duty_next = up[LEVEL_W] ? g1 : up[LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg <= '0;
            goal_reg <= '0;
            mode_reg <= BLINK_RST ? MODE_BLINK : MODE_WAIT;
            en_reg   <= BLINK_RST;
        end
        else if (ctl.frame)
        begin
            duty_reg <= duty_next;
            goal_reg <= goal_next;
            mode_reg <= mode_next;
            en_reg   <= en_next;
        end
    end

    assign level  = duty_reg;
    assign enable = en_reg;

endmodule
